// ----- src/fsp_pkg.sv -----
// Shared types and constants of the format specifier parser.
// No dependencies; imported by format_specifier_parser.
`default_nettype none

package fsp_pkg;

  // Default saturation width of the width and precision numbers
  localparam int unsigned FSP_NUMBER_BITS = 16;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_LITERAL = 2'd0,
    KIND_DESC    = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  // Conversion codes
  typedef enum logic [3:0] {
    CONV_D     = 4'd0,
    CONV_C     = 4'd1,
    CONV_U     = 4'd2,
    CONV_O     = 4'd3,
    CONV_X     = 4'd4,
    CONV_BIG_X = 4'd5,
    CONV_F     = 4'd6,
    CONV_BIG_F = 4'd7,
    CONV_E     = 4'd8,
    CONV_BIG_E = 4'd9,
    CONV_G     = 4'd10,
    CONV_BIG_G = 4'd11,
    CONV_S     = 4'd12,
    CONV_P     = 4'd13
  } conv_t;

  // Length modifier codes
  typedef enum logic [2:0] {
    LEN_NONE  = 3'd0,
    LEN_HH    = 3'd1,
    LEN_H     = 3'd2,
    LEN_L     = 3'd3,
    LEN_LL    = 3'd4,
    LEN_BIG_L = 3'd5
  } len_t;

  // Format characters
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LC_H    = 8'h68;
  localparam logic [7:0] CH_LC_L    = 8'h6C;
  localparam logic [7:0] CH_UC_L    = 8'h4C;
  localparam logic [7:0] CH_LC_D    = 8'h64;
  localparam logic [7:0] CH_LC_I    = 8'h69;
  localparam logic [7:0] CH_LC_C    = 8'h63;
  localparam logic [7:0] CH_LC_U    = 8'h75;
  localparam logic [7:0] CH_LC_O    = 8'h6F;
  localparam logic [7:0] CH_LC_X    = 8'h78;
  localparam logic [7:0] CH_UC_X    = 8'h58;
  localparam logic [7:0] CH_LC_F    = 8'h66;
  localparam logic [7:0] CH_UC_F    = 8'h46;
  localparam logic [7:0] CH_LC_E    = 8'h65;
  localparam logic [7:0] CH_UC_E    = 8'h45;
  localparam logic [7:0] CH_LC_G    = 8'h67;
  localparam logic [7:0] CH_UC_G    = 8'h47;
  localparam logic [7:0] CH_LC_S    = 8'h73;
  localparam logic [7:0] CH_LC_P    = 8'h70;

endpackage

`default_nettype wire

// ----- src/format_specifier_parser.sv -----
// Format specifier parser top level: input register, parse logic, result register.
// Depends on fsp_pkg.
`default_nettype none

// Takes one format-string byte per transfer and returns at most one result per
// byte: a literal byte, a conversion descriptor or a format error. One byte is
// taken every clock cycle while results are drained; a byte is held in the
// input register, where the parse state is updated by a single decision plus
// one multiply-by-ten accumulate, and the result then waits in the output
// register. Between its input transfer and its result transfer a byte passes the
// input register and then the output register. A NUL byte produces no result
// and returns the parser to its reset state; after an error all bytes up to the
// next NUL are dropped. Width and precision saturate at 2**NUMBER_BITS - 1.
module format_specifier_parser
  import fsp_pkg::*;
#(
  parameter int unsigned NUMBER_BITS = FSP_NUMBER_BITS
) (
  input  wire                    clk,
  input  wire                    rst_n,
  // byte input
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire  [7:0]             in_fmt_byte,
  // result output
  output logic                   out_valid,
  input  wire                    out_ready,
  output logic [1:0]             out_kind,
  output logic [7:0]             out_literal_byte,
  output logic [3:0]             out_conv_code,
  output logic                   out_left_adjust,
  output logic                   out_width_given,
  output logic [NUMBER_BITS-1:0] out_field_width,
  output logic                   out_prec_given,
  output logic [NUMBER_BITS-1:0] out_prec_value,
  output logic [2:0]             out_length_code
);

  localparam int unsigned AccW = NUMBER_BITS + 4;
  localparam logic [AccW-1:0] NumMax = AccW'({NUMBER_BITS{1'b1}});

  typedef enum logic [1:0] {
    PH_LIT  = 2'd0,
    PH_SPEC = 2'd1,
    PH_ERR  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    DT_NONE  = 2'd0,
    DT_WIDTH = 2'd1,
    DT_PREC  = 2'd2
  } dtgt_t;

  // Input stage
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_adv;
  logic       s1_fire;

  // Parse state
  phase_t                 phase_r, phase_nxt;
  logic                   f_minus_r, f_minus_nxt;
  logic                   f_width_r, f_width_nxt;
  logic                   f_prec_r, f_prec_nxt;
  logic                   f_len_r, f_len_nxt;
  dtgt_t                  dtgt_r, dtgt_nxt;
  logic [NUMBER_BITS-1:0] width_acc_r, width_acc_nxt;
  logic [NUMBER_BITS-1:0] prec_acc_r, prec_acc_nxt;
  len_t                   len_r, len_nxt;

  // Result of the current byte
  logic       res_valid;
  kind_t      res_kind;
  logic [7:0] res_lit;
  conv_t      res_conv;
  logic       res_desc;

  // Output register
  logic                   out_valid_r;
  kind_t                  out_kind_r;
  logic [7:0]             out_lit_r;
  conv_t                  out_conv_r;
  logic                   out_ladj_r;
  logic                   out_wgiven_r;
  logic [NUMBER_BITS-1:0] out_width_r;
  logic                   out_pgiven_r;
  logic [NUMBER_BITS-1:0] out_prec_r;
  len_t                   out_len_r;

  logic       out_load_ok;
  logic       is_digit;
  logic [3:0] digit;
  logic [AccW-1:0] acc_src;
  logic [AccW-1:0] acc_sum;
  logic [NUMBER_BITS-1:0] acc_sat;

  // Handshake: a byte leaves stage 1 unless its result cannot enter the output register
  assign out_load_ok = !out_valid_r || out_ready;
  assign s1_adv      = !res_valid || out_load_ok;
  assign s1_fire     = s1_valid_r && s1_adv;
  assign in_ready    = !s1_valid_r || s1_adv;

  // Digit decode and saturating acc*10 + d
  assign is_digit = (s1_byte_r >= CH_ZERO) && (s1_byte_r <= CH_NINE);
  assign digit    = 4'(s1_byte_r - CH_ZERO);
  assign acc_src  = (dtgt_r == DT_PREC) ? AccW'(prec_acc_r) : AccW'(width_acc_r);
  assign acc_sum  = (acc_src << 3) + (acc_src << 1) + AccW'(digit);
  assign acc_sat  = (acc_sum > NumMax) ? NUMBER_BITS'(NumMax) : acc_sum[NUMBER_BITS-1:0];

  // Parse decision for the byte in stage 1
  always_comb begin
    logic err;
    logic clr;
    err           = 1'b0;
    clr           = 1'b0;
    phase_nxt     = phase_r;
    f_minus_nxt   = f_minus_r;
    f_width_nxt   = f_width_r;
    f_prec_nxt    = f_prec_r;
    f_len_nxt     = f_len_r;
    dtgt_nxt      = dtgt_r;
    width_acc_nxt = width_acc_r;
    prec_acc_nxt  = prec_acc_r;
    len_nxt       = len_r;
    res_valid     = 1'b0;
    res_kind      = KIND_LITERAL;
    res_lit       = s1_byte_r;
    res_conv      = CONV_D;
    res_desc      = 1'b0;

    if (s1_byte_r == CH_NUL) begin
      clr = 1'b1;
    end else if (phase_r == PH_ERR) begin
      // dropped
    end else if (phase_r == PH_LIT) begin
      if (s1_byte_r == CH_PERCENT) begin
        clr       = 1'b1;
        phase_nxt = PH_SPEC;
      end else begin
        res_valid = 1'b1;
      end
    end else if (is_digit) begin
      if (dtgt_r == DT_WIDTH) begin
        width_acc_nxt = acc_sat;
      end else if (dtgt_r == DT_PREC) begin
        prec_acc_nxt = acc_sat;
      end else if (!f_width_r && !f_prec_r && !f_len_r) begin
        f_width_nxt   = 1'b1;
        dtgt_nxt      = DT_WIDTH;
        width_acc_nxt = NUMBER_BITS'(digit);
      end else begin
        err = 1'b1;
      end
    end else begin
      dtgt_nxt = DT_NONE;
      unique case (s1_byte_r)
        CH_MINUS: begin
          if (f_width_r || f_prec_r || f_len_r) err = 1'b1;
          else f_minus_nxt = 1'b1;
        end
        CH_DOT: begin
          if (f_prec_r || f_len_r) begin
            err = 1'b1;
          end else begin
            f_prec_nxt   = 1'b1;
            dtgt_nxt     = DT_PREC;
            prec_acc_nxt = '0;
          end
        end
        CH_LC_H: begin
          priority if (len_r == LEN_NONE) len_nxt = LEN_H;
          else if (len_r == LEN_H) len_nxt = LEN_HH;
          else err = 1'b1;
          f_len_nxt = 1'b1;
        end
        CH_LC_L: begin
          priority if (len_r == LEN_NONE) len_nxt = LEN_L;
          else if (len_r == LEN_L) len_nxt = LEN_LL;
          else err = 1'b1;
          f_len_nxt = 1'b1;
        end
        CH_UC_L: begin
          if (len_r != LEN_NONE) err = 1'b1;
          else len_nxt = LEN_BIG_L;
          f_len_nxt = 1'b1;
        end
        CH_LC_D, CH_LC_I, CH_LC_U, CH_LC_O, CH_LC_X, CH_UC_X: begin
          unique case (s1_byte_r)
            CH_LC_U: res_conv = CONV_U;
            CH_LC_O: res_conv = CONV_O;
            CH_LC_X: res_conv = CONV_X;
            CH_UC_X: res_conv = CONV_BIG_X;
            default: res_conv = CONV_D;
          endcase
          if (len_r == LEN_BIG_L) err = 1'b1;
          else res_desc = 1'b1;
        end
        CH_LC_C: begin
          res_conv = CONV_C;
          if (f_prec_r || f_len_r) err = 1'b1;
          else res_desc = 1'b1;
        end
        CH_LC_F, CH_UC_F, CH_LC_E, CH_UC_E, CH_LC_G, CH_UC_G: begin
          unique case (s1_byte_r)
            CH_LC_F: res_conv = CONV_F;
            CH_UC_F: res_conv = CONV_BIG_F;
            CH_LC_E: res_conv = CONV_E;
            CH_UC_E: res_conv = CONV_BIG_E;
            CH_LC_G: res_conv = CONV_G;
            default: res_conv = CONV_BIG_G;
          endcase
          if (f_len_r && len_r != LEN_L && len_r != LEN_BIG_L) err = 1'b1;
          else res_desc = 1'b1;
        end
        CH_LC_S: begin
          res_conv = CONV_S;
          if (f_len_r) err = 1'b1;
          else res_desc = 1'b1;
        end
        CH_LC_P: begin
          res_conv = CONV_P;
          if (f_len_r || f_prec_r) err = 1'b1;
          else res_desc = 1'b1;
        end
        CH_PERCENT: begin
          // percent inside a specifier prints itself and drops the specifier
          clr       = 1'b1;
          res_valid = 1'b1;
        end
        default: err = 1'b1;
      endcase
    end

    if (res_desc) begin
      res_valid = 1'b1;
      res_kind  = KIND_DESC;
      clr       = 1'b1;
    end
    if (err) begin
      res_valid = 1'b1;
      res_kind  = KIND_ERROR;
      res_desc  = 1'b0;
      clr       = 1'b1;
    end
    if (clr) begin
      if (!(phase_r == PH_LIT && s1_byte_r == CH_PERCENT && !err)) phase_nxt = PH_LIT;
      f_minus_nxt   = 1'b0;
      f_width_nxt   = 1'b0;
      f_prec_nxt    = 1'b0;
      f_len_nxt     = 1'b0;
      dtgt_nxt      = DT_NONE;
      width_acc_nxt = '0;
      prec_acc_nxt  = '0;
      len_nxt       = LEN_NONE;
    end
    if (err) phase_nxt = PH_ERR;
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
    if (in_ready && in_valid) s1_byte_r <= in_fmt_byte;
  end

  // Parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LIT;
      f_minus_r   <= 1'b0;
      f_width_r   <= 1'b0;
      f_prec_r    <= 1'b0;
      f_len_r     <= 1'b0;
      dtgt_r      <= DT_NONE;
      width_acc_r <= '0;
      prec_acc_r  <= '0;
      len_r       <= LEN_NONE;
    end else if (s1_fire) begin
      phase_r     <= phase_nxt;
      f_minus_r   <= f_minus_nxt;
      f_width_r   <= f_width_nxt;
      f_prec_r    <= f_prec_nxt;
      f_len_r     <= f_len_nxt;
      dtgt_r      <= dtgt_nxt;
      width_acc_r <= width_acc_nxt;
      prec_acc_r  <= prec_acc_nxt;
      len_r       <= len_nxt;
    end
  end

  // Output register; fields not used by the result kind are zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load_ok) begin
      out_valid_r <= s1_valid_r && res_valid;
    end
    if (out_load_ok && s1_valid_r && res_valid) begin
      out_kind_r   <= res_kind;
      out_lit_r    <= (res_kind == KIND_LITERAL) ? res_lit : 8'h00;
      out_conv_r   <= res_desc ? res_conv : CONV_D;
      out_ladj_r   <= res_desc && f_minus_r;
      out_wgiven_r <= res_desc && f_width_r;
      out_width_r  <= res_desc ? width_acc_r : '0;
      out_pgiven_r <= res_desc && f_prec_r;
      out_prec_r   <= res_desc ? prec_acc_r : '0;
      out_len_r    <= res_desc ? len_r : LEN_NONE;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_literal_byte = out_lit_r;
  assign out_conv_code    = out_conv_r;
  assign out_left_adjust  = out_ladj_r;
  assign out_width_given  = out_wgiven_r;
  assign out_field_width  = out_width_r;
  assign out_prec_given   = out_pgiven_r;
  assign out_prec_value   = out_prec_r;
  assign out_length_code  = out_len_r;

  // Checks
  a_nul_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_byte_r == CH_NUL) |=> (phase_r == PH_LIT && width_acc_r == '0 &&
      prec_acc_r == '0 && len_r == LEN_NONE))
    else $error("NUL did not reset parse state");

  a_err_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && res_valid && res_kind == KIND_ERROR) |=> (phase_r == PH_ERR))
    else $error("error result without error phase");

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_ERR) |-> (dtgt_r == DT_NONE && !f_minus_r && !f_width_r &&
      !f_prec_r && !f_len_r))
    else $error("parse state not cleared in error phase");

  a_lit_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r != KIND_DESC) |-> (out_conv_r == CONV_D &&
      out_width_r == '0 && out_prec_r == '0 && out_len_r == LEN_NONE))
    else $error("descriptor fields set on a non-descriptor result");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r)
    else $error("pending result lost");

endmodule

`default_nettype wire
